>>> sv/qpht_pkg.sv
// ----------------------------------------------------------------------------
// qpht_pkg
// Shared types and constants of the quadratic probe hash table.
// ----------------------------------------------------------------------------
`default_nettype none

package qpht_pkg;

  localparam int TableDepth = 1024;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int SizeW      = 11;
  localparam int KeyW       = 31;
  localparam int SlotIdxW   = 10;
  localparam int KindW      = 2;
  localparam int StW        = 2;

  localparam logic [SizeW-1:0] SizeReset = SizeW'(1021);

  typedef enum logic [KindW-1:0] {
    KIND_FIND   = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_DELETE = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [StW-1:0] {
    ST_EMPTY   = 2'd0,
    ST_LIVE    = 2'd1,
    ST_DELETED = 2'd2,
    ST_UNUSED  = 2'd3
  } slot_st_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // latch request, start key reduction
    logic div_step;   // one restoring division step
    logic probe_rd;   // issue memory read at current probe index
    logic probe_adv;  // advance probe index
    logic commit;     // write back and build result
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
    logic stop;       // probed slot ends the walk
    logic limit;      // last allowed probe
  } dp_sts_t;

endpackage

`default_nettype wire

>>> sv/qpht_if.sv
// ----------------------------------------------------------------------------
// qpht_req_if / qpht_rsp_if
// Valid/ready channels of the hash table.
// ----------------------------------------------------------------------------
`default_nettype none

interface qpht_req_if;
  logic                      valid;
  logic                      ready;
  logic [qpht_pkg::KindW-1:0] kind;
  logic [qpht_pkg::KeyW-1:0]  key;
  modport source (output valid, kind, key, input ready);
  modport sink   (input valid, kind, key, output ready);
endinterface

interface qpht_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         success;
  logic [qpht_pkg::SlotIdxW-1:0] slot_index;
  logic [qpht_pkg::StW-1:0]      slot_state;
  logic [qpht_pkg::KeyW-1:0]     slot_key;
  modport source (output valid, success, slot_index, slot_state, slot_key, input ready);
  modport sink   (input valid, success, slot_index, slot_state, slot_key, output ready);
endinterface

`default_nettype wire

>>> sv/qpht_ctrl.sv
// ----------------------------------------------------------------------------
// qpht_ctrl
// Sequencer: clearing pass, key reduction, probe walk, commit, result hold.
// ----------------------------------------------------------------------------
`default_nettype none

module qpht_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire logic              clr_done,
  output qpht_pkg::dp_cmd_t      cmd,
  input  wire qpht_pkg::dp_sts_t sts
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_DIV, S_READ, S_CHECK, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // next state
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      S_CLEAR: if (clr_done) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.probe_rd = 1'b1;
          state_nxt    = S_CHECK;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_READ: begin
        cmd.probe_rd = 1'b1;
        state_nxt    = S_CHECK;
      end
      S_CHECK: begin
        if (sts.stop || sts.limit) begin
          state_nxt = S_DONE;
        end else begin
          cmd.probe_adv = 1'b1;
          state_nxt     = S_READ;
        end
      end
      S_DONE: begin
        // result register free: commit and show
        if (!out_valid_r || out_ready) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

>>> sv/qpht_dp.sv
// ----------------------------------------------------------------------------
// qpht_dp
// Datapath: bit-serial key reduction, probe index update, slot memories.
// ----------------------------------------------------------------------------
`default_nettype none

module qpht_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [qpht_pkg::SizeW-1:0]    cfg_wdata,
  input  wire logic [qpht_pkg::KindW-1:0]    in_kind,
  input  wire logic [qpht_pkg::KeyW-1:0]     in_key,
  input  wire qpht_pkg::dp_cmd_t             cmd,
  output qpht_pkg::dp_sts_t                  sts,
  output logic                               clr_done,
  output logic                               res_success,
  output logic [qpht_pkg::SlotIdxW-1:0]      res_index,
  output logic [qpht_pkg::StW-1:0]           res_state,
  output logic [qpht_pkg::KeyW-1:0]          res_key
);

  localparam int IdxW  = qpht_pkg::IdxW;
  localparam int KeyW  = qpht_pkg::KeyW;
  localparam int SzW   = IdxW + 1;              // holds TableDepth itself
  localparam int CntW  = $clog2(KeyW + 1);

  // configuration register and saturated size
  logic [qpht_pkg::SizeW-1:0] size_cfg_r;
  logic [SzW-1:0]             eff_size;

  always_ff @(posedge clk) begin
    if (!rst_n) size_cfg_r <= qpht_pkg::SizeReset;
    else if (cfg_we) size_cfg_r <= cfg_wdata;
  end

  always_comb begin
    if (size_cfg_r < qpht_pkg::SizeW'(2)) eff_size = SzW'(2);
    else if (32'(size_cfg_r) > qpht_pkg::TableDepth) eff_size = SzW'(qpht_pkg::TableDepth);
    else eff_size = SzW'(size_cfg_r);
  end

  // request registers
  logic [qpht_pkg::KindW-1:0] kind_r;
  logic [KeyW-1:0]            key_r;
  logic [SzW-1:0]             size_r;
  // restoring remainder
  logic [KeyW-1:0]            quo_r;
  logic [SzW:0]               rem_r;
  logic [CntW-1:0]            dcnt_r;
  // probe walk: idx, increment 2i+1 kept mod size, probe count
  logic [IdxW-1:0]            idx_r;
  logic [SzW-1:0]             inc_r;
  logic [SzW-1:0]             pcnt_r;
  logic [SzW-1:0]             plimit_r;

  logic [SzW:0] rem_sh, rem_sub;
  assign rem_sh  = {rem_r[SzW-1:0], quo_r[KeyW-1]};
  assign rem_sub = rem_sh - {1'b0, size_r};

  // next probe index and increment: one compare and subtract for the index, two for the increment
  logic [SzW:0] idx_sum, inc_sum;
  logic [SzW-1:0] idx_next, inc_next;
  always_comb begin
    idx_sum  = (SzW+1)'(idx_r) + (SzW+1)'(inc_r);
    idx_next = (idx_sum >= (SzW+1)'(size_r)) ? SzW'(idx_sum - (SzW+1)'(size_r))
                                             : SzW'(idx_sum);
    inc_sum  = (SzW+1)'(inc_r) + (SzW+1)'(2);
    if (inc_sum >= (SzW+1)'(size_r)) inc_sum = inc_sum - (SzW+1)'(size_r);
    inc_next = (inc_sum >= (SzW+1)'(size_r)) ? SzW'(inc_sum - (SzW+1)'(size_r))
                                             : SzW'(inc_sum);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r   <= in_kind;
      key_r    <= in_key;
      size_r   <= eff_size;
      quo_r    <= in_key;
      rem_r    <= '0;
      dcnt_r   <= '0;
      plimit_r <= (eff_size >> 1) + SzW'(1);
    end else if (cmd.div_step) begin
      quo_r  <= {quo_r[KeyW-2:0], 1'b0};
      rem_r  <= rem_sub[SzW] ? rem_sh : rem_sub;
      dcnt_r <= dcnt_r + CntW'(1);
    end
    if (cmd.load) begin
      pcnt_r <= '0;
      inc_r  <= SzW'(1);
    end else if (cmd.div_step) begin
      idx_r  <= rem_sub[SzW] ? IdxW'(rem_sh) : IdxW'(rem_sub);
    end else if (cmd.probe_adv) begin
      idx_r  <= IdxW'(idx_next);
      inc_r  <= inc_next;
      pcnt_r <= pcnt_r + SzW'(1);
    end
  end

  // slot memories: status is cleared by a sweep after reset
  logic [qpht_pkg::StW-1:0] st_mem [qpht_pkg::TableDepth];
  logic [KeyW-1:0]          key_mem [qpht_pkg::TableDepth];
  logic [qpht_pkg::StW-1:0] st_rd_r;
  logic [KeyW-1:0]          key_rd_r;
  logic [SzW-1:0]           clr_r;

  logic                     st_we;
  logic [IdxW-1:0]          st_wa;
  logic [qpht_pkg::StW-1:0] st_wd;
  logic                     is_match, do_ins, do_del;

  assign clr_done = clr_r[SzW-1];
  assign is_match = (st_rd_r == qpht_pkg::ST_LIVE) && (key_rd_r == key_r);
  assign do_ins   = (kind_r == qpht_pkg::KIND_INSERT) &&
                    ((st_rd_r == qpht_pkg::ST_EMPTY) || (st_rd_r == qpht_pkg::ST_DELETED));
  assign do_del   = (kind_r == qpht_pkg::KIND_DELETE) && is_match;

  always_comb begin
    st_we = 1'b0;
    st_wa = idx_r;
    st_wd = qpht_pkg::ST_LIVE;
    if (!clr_done) begin
      st_we = 1'b1;
      st_wa = clr_r[IdxW-1:0];
      st_wd = qpht_pkg::ST_EMPTY;
    end else if (cmd.commit && do_ins) begin
      st_we = 1'b1;
    end else if (cmd.commit && do_del) begin
      st_we = 1'b1;
      st_wd = qpht_pkg::ST_DELETED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) clr_r <= '0;
    else if (!clr_done) clr_r <= clr_r + SzW'(1);
  end

  always_ff @(posedge clk) begin
    if (st_we) st_mem[st_wa] <= st_wd;
    if (cmd.commit && do_ins) key_mem[idx_r] <= key_r;
    if (cmd.probe_rd) begin
      st_rd_r  <= st_mem[idx_r];
      key_rd_r <= key_mem[idx_r];
    end
  end

  // status to the controller
  assign sts = '{div_done: (dcnt_r == CntW'(KeyW)),
                 stop:     !((st_rd_r == qpht_pkg::ST_LIVE) && (key_rd_r != key_r)),
                 limit:    (pcnt_r == plimit_r)};

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_index <= qpht_pkg::SlotIdxW'(idx_r);
      res_state <= st_rd_r;
      res_key   <= (st_rd_r == qpht_pkg::ST_EMPTY) ? '0 : key_rd_r;
      case (kind_r)
        qpht_pkg::KIND_FIND: res_success <= is_match;
        qpht_pkg::KIND_INSERT: res_success <= do_ins;
        qpht_pkg::KIND_DELETE: res_success <= do_del;
        default: res_success <= 1'b0;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> sv/quadratic_probe_hash_table.sv
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table
// Open-addressing hash table with quadratic probing, one request at a time.
// ----------------------------------------------------------------------------
// After reset the block sweeps the slot status memory and takes no request
// until done. Each request is loaded, then the key is reduced modulo the
// table size (one remainder bit a cycle), then each probe reads the status and
// key memories through their read port and checks the slot (the first read is
// issued in the cycle that sees the reduction done), then the result is
// committed once the output register is free. A walk makes between 1 and
// size/2+2 probes. The result waits in an output register; the next request
// is taken once it is shown.
`default_nettype none

module quadratic_probe_hash_table (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  qpht_req_if.sink                        in_ch,
  qpht_rsp_if.source                      out_ch,
  input  wire logic                       cfg_we,
  input  wire logic [qpht_pkg::SizeW-1:0] cfg_wdata
);

  qpht_pkg::dp_cmd_t cmd;
  qpht_pkg::dp_sts_t sts;
  logic              clr_done;

  qpht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .clr_done  (clr_done),
    .cmd       (cmd),
    .sts       (sts)
  );

  qpht_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_kind     (in_ch.kind),
    .in_key      (in_ch.key),
    .cmd         (cmd),
    .sts         (sts),
    .clr_done    (clr_done),
    .res_success (out_ch.success),
    .res_index   (out_ch.slot_index),
    .res_state   (out_ch.slot_state),
    .res_key     (out_ch.slot_key)
  );

endmodule

`default_nettype wire

>>> sv/qpht_checker.sv
// ----------------------------------------------------------------------------
// qpht_checker
// Port-level checks of the hash table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module qpht_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [1:0] slot_state,
  input wire logic [30:0] slot_key
);

  // one request in flight: no accept right after an accept
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // an empty slot reports key zero
  a_empty_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && slot_state == 2'd0 |-> slot_key == '0)
    else $error("empty slot with nonzero key");

  // reported state never the unused code
  a_state_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> slot_state != 2'd3)
    else $error("bad slot state");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(slot_key))
    else $error("result dropped under stall");

endmodule

bind quadratic_probe_hash_table qpht_checker u_qpht_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .slot_state (out_ch.slot_state),
  .slot_key   (out_ch.slot_key)
);

`default_nettype wire
